[design/fslsm_pkg.sv]
// shared types and constants for the flash sample log slot manager
// no dependencies
`default_nettype none

package fslsm_pkg;

   localparam int SECTORS_DEF      = 16;
   localparam int SLOTS_DEF        = 254;
   localparam int MAP_BYTES_DEF    = 32;
   localparam int RECORD_BYTES_DEF = 16;

   localparam int IDX_W       = 6;
   localparam int STAMP_W     = 32;
   localparam int SECTOR_W    = 8;
   localparam int SLOT_W      = 8;
   localparam int ADDR_W      = 24;
   localparam int MAP_OFS_W   = 5;
   localparam int REQ_DATA_W  = 112;
   localparam int RSP_DATA_W  = 96;
   localparam int SECTOR_SHIFT = 12;

   localparam logic [SECTOR_W-1:0] FIRST_SECTOR_RST = 8'hF0;
   localparam logic [STAMP_W-1:0]  STAMP_MAX        = 32'hFFFF_FFFF;
   localparam logic [7:0]          MAP_ALL_FREE     = 8'hFF;

   localparam logic KIND_STORE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic                 valid;
      logic                 kind;
      logic                 found;
      logic                 erase;
      logic [IDX_W-1:0]     pick;
      logic [IDX_W-1:0]     alt;
      logic [SLOT_W-1:0]    slot;
      logic [STAMP_W-1:0]   stamp;
      logic [STAMP_W-1:0]   key;
   } tok_type;

   typedef struct packed {
      logic                 valid;
      logic [IDX_W-1:0]     idx;
      logic [SLOT_W-1:0]    slot;
      logic [STAMP_W-1:0]   stamp;
   } upd_type;

endpackage

`default_nettype wire

[design/flash_sample_log_slot_manager.sv]
// an accepted req beat walks the row of sector cells one entry per cycle, then is
// resolved from the hold register and loaded into the result register once the
// output is free; the next req beat is taken only after that load, and a new
// req beat is taken while the previous rsp beat still waits
// reset: synchronous, clears all slot counts and set-up flags, first_sector to 0xF0
// top level: control, result register and the cell row; uses fslsm_pkg, fslsm_cell
`default_nettype none

module flash_sample_log_slot_manager #(
   parameter int SECTORS      = fslsm_pkg::SECTORS_DEF,
   parameter int SLOTS        = fslsm_pkg::SLOTS_DEF,
   parameter int MAP_BYTES    = fslsm_pkg::MAP_BYTES_DEF,
   parameter int RECORD_BYTES = fslsm_pkg::RECORD_BYTES_DEF
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     csr_wen,
   input  wire  [fslsm_pkg::SECTOR_W-1:0]          csr_wdata,
   input  wire                                     req_tvalid,
   output logic                                    req_tready,
   // log_stamp, humidity_value, temperature_value, soil_value, query_limit, pad
   input  wire  [fslsm_pkg::REQ_DATA_W-1:0]        req_tdata,
   // kind
   input  wire                                     req_tuser,
   output logic                                    rsp_tvalid,
   input  wire                                     rsp_tready,
   // target_sector, erase_first, slot_index, sample_address, map_offset,
   // map_value, newest_found, newest_sector, newest_time, pad
   output logic [fslsm_pkg::RSP_DATA_W-1:0]        rsp_tdata
);
   import fslsm_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [SECTOR_W-1:0]   first_sector_ff;
   tok_type               hold_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   tok_type               chain [SECTORS+1];
   tok_type               inject;
   upd_type               upd;

   logic                  accept;
   logic                  out_free;
   logic                  load;

   logic [IDX_W-1:0]      res_pick;
   logic                  res_erase;
   logic [SLOT_W-1:0]     res_slot;
   logic [SECTOR_W-1:0]   res_sec;
   logic [ADDR_W-1:0]     res_addr;
   logic [7:0]            res_map;
   logic [3:0]            res_shift;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load       = (state_ff == ST_HOLD) && out_free;

   always_comb begin
      inject.valid = accept;
      inject.kind  = req_tuser;
      inject.found = 1'b0;
      inject.erase = 1'b0;
      inject.pick  = '0;
      inject.alt   = '0;
      inject.slot  = '0;
      if (req_tuser == KIND_STORE) begin
         inject.stamp = STAMP_MAX;
         inject.key   = req_tdata[31:0];
      end else begin
         inject.stamp = '0;
         inject.key   = req_tdata[105:74];
      end
   end

   assign chain[0] = inject;

   for (genvar i = 0; i < SECTORS; i++) begin : g_cell
      fslsm_cell #(
         .SLOTS    (SLOTS),
         .CELL_IDX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .prev_tok (chain[i]),
         .upd      (upd),
         .next_tok (chain[i+1])
      );
   end

   // resolve the store choice, falling back to the oldest entry
   always_comb begin
      res_pick  = hold_ff.found ? hold_ff.pick  : hold_ff.alt;
      res_erase = hold_ff.found ? hold_ff.erase : 1'b1;
      res_slot  = hold_ff.found ? hold_ff.slot  : '0;
      res_sec   = first_sector_ff + SECTOR_W'(res_pick);
      res_addr  = ADDR_W'({res_sec, {SECTOR_SHIFT{1'b0}}})
                + ADDR_W'(MAP_BYTES)
                + ADDR_W'(res_slot) * ADDR_W'(RECORD_BYTES);
      res_shift = {1'b0, res_slot[2:0]} + 4'd1;
      res_map   = MAP_ALL_FREE << res_shift;
   end

   always_comb begin
      rsp_data_in = '0;
      if (hold_ff.kind == KIND_STORE) begin
         rsp_data_in[7:0]   = res_sec;
         rsp_data_in[8]     = res_erase;
         rsp_data_in[16:9]  = res_slot;
         rsp_data_in[40:17] = res_addr;
         rsp_data_in[45:41] = res_slot[7:3];
         rsp_data_in[53:46] = res_map;
      end else begin
         rsp_data_in[54]    = hold_ff.found;
         rsp_data_in[62:55] = hold_ff.found ? (first_sector_ff + SECTOR_W'(hold_ff.pick))
                                            : '0;
         rsp_data_in[94:63] = hold_ff.stamp;
      end
   end

   always_comb begin
      upd.valid = load && (hold_ff.kind == KIND_STORE);
      upd.idx   = res_pick;
      upd.slot  = res_slot;
      upd.stamp = hold_ff.key;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_BUSY;
         end
         ST_BUSY: begin
            if (chain[SECTORS].valid) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_sector_ff <= FIRST_SECTOR_RST;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) first_sector_ff <= csr_wdata;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_BUSY) && chain[SECTORS].valid) hold_ff <= chain[SECTORS];
      if (load) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[design/fslsm_cell.sv]
// one sector entry of the slot manager chain: holds its counts and stamps
// and refines the search beat handed along from the previous entry; uses fslsm_pkg
`default_nettype none

module fslsm_cell #(
   parameter int SLOTS    = fslsm_pkg::SLOTS_DEF,
   parameter int CELL_IDX = 0
) (
   input  wire                    clock,
   input  wire                    reset,
   input  fslsm_pkg::tok_type     prev_tok,
   input  fslsm_pkg::upd_type     upd,
   output fslsm_pkg::tok_type     next_tok
);
   import fslsm_pkg::*;

   localparam logic [IDX_W-1:0]  MY_IDX   = IDX_W'(CELL_IDX);
   localparam logic [SLOT_W-1:0] SLOT_CAP = SLOT_W'(SLOTS);

   logic                ready_ff;
   logic [SLOT_W-1:0]   cnt_ff;
   logic [STAMP_W-1:0]  first_ff;
   logic [STAMP_W-1:0]  last_ff;
   logic                valid_ff;
   tok_type             tok_ff;
   tok_type             tok_in;
   logic                hit;

   assign hit = upd.valid && (upd.idx == MY_IDX);

   always_comb begin
      tok_in = prev_tok;
      if (prev_tok.kind == KIND_STORE) begin
         if (!prev_tok.found) begin
            if (!ready_ff) begin
               tok_in.found = 1'b1;
               tok_in.erase = 1'b1;
               tok_in.pick  = MY_IDX;
               tok_in.slot  = '0;
            end else if (cnt_ff < SLOT_CAP) begin
               tok_in.found = 1'b1;
               tok_in.erase = 1'b0;
               tok_in.pick  = MY_IDX;
               tok_in.slot  = cnt_ff;
            end
         end
         // oldest first stamp, used only when every entry is set up and full
         if (first_ff < prev_tok.stamp) begin
            tok_in.stamp = first_ff;
            tok_in.alt   = MY_IDX;
         end
      end else begin
         if ((cnt_ff != '0) && (last_ff > prev_tok.stamp) && (last_ff <= prev_tok.key)) begin
            tok_in.found = 1'b1;
            tok_in.stamp = last_ff;
            tok_in.pick  = MY_IDX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tok_in.valid;
         if (hit) begin
            ready_ff <= 1'b1;
            cnt_ff   <= upd.slot + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      if (hit) begin
         last_ff <= upd.stamp;
         if (upd.slot == '0) begin
            first_ff <= upd.stamp;
         end
      end
   end

   always_comb begin
      next_tok       = tok_ff;
      next_tok.valid = valid_ff;
   end

endmodule

`default_nettype wire
